@@ src/n2w_pkg.sv @@
// Package with the word codes and sequencer state type for the number-to-words block.
`timescale 1ns / 1ps

package n2w_pkg;

    typedef logic [5:0] word_code_t;

    localparam word_code_t CODE_ZERO      = 6'd0;
    localparam word_code_t CODE_TEEN_BASE = 6'd10;
    localparam word_code_t CODE_TENS_BASE = 6'd18;
    localparam word_code_t CODE_HUNDRED   = 6'd28;
    localparam word_code_t CODE_THOUSAND  = 6'd29;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_ZERO,
        ST_SCAN,
        ST_HUND_DIGIT,
        ST_HUND_WORD,
        ST_TENS,
        ST_ONES,
        ST_SCALE
    } state_t;

endpackage

@@ src/number_to_word_tokens_top.sv @@
// Top level of the number-to-words block: bit-serial BCD conversion and word sequencer.
`timescale 1ns / 1ps

// Names a non-negative integer in English words (short scale), one word code per
// output transaction, most significant word first, with tlast on the final word.
// An accepted value is converted to BCD one bit per cycle by a shift-and-add-3
// register, then checked for zero, then the three-digit groups are walked from
// the highest: each group is inspected, and a nonzero group steps through its
// hundreds digit, Hundred where the group has a hundreds digit, its tens, teen
// or lone ones word, its ones word and its scale word, one word at most per
// cycle while the output takes them. One item is worked on at a time. A stalled
// output holds the sequencer on the word it offers. A word waiting in the output
// register does not block the next value from being accepted.
module number_to_word_tokens_top #(
    parameter int VALUE_WIDTH = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [62:0] value, [63] zero pad
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] word_code, [7:6] zero pad
    output logic        m_tlast    // last_word
);

    import n2w_pkg::*;

    localparam int NDIG = (VALUE_WIDTH * 301) / 1000 + 1;
    localparam int NGRP = (NDIG + 2) / 3;
    localparam int BW   = NGRP * 12;
    localparam int CW   = $clog2(VALUE_WIDTH);
    localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;

    state_t                  state_reg, state_next;
    logic [VALUE_WIDTH-1:0]  sh_reg, sh_next;
    logic [BW-1:0]           bcd_reg, bcd_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [GW-1:0]           grp_idx_reg, grp_idx_next;

    logic                    out_valid_reg;
    word_code_t              out_code_reg;
    logic                    out_last_reg;

    logic [BW-1:0]           bcd_adj;
    logic [11:0]             grp;
    logic [3:0]              dig_h, dig_t, dig_o;
    logic                    lower_nz;
    logic                    grp_nz;
    logic                    can_emit;
    logic                    emit_req;
    word_code_t              emit_code;
    logic                    emit_last;
    logic                    em_tens, em_ones, em_scale;

    // Add three to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NGRP * 3; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    // Top group and what follows it
    assign grp      = bcd_reg[BW-1 -: 12];
    assign dig_h    = grp[11:8];
    assign dig_t    = grp[7:4];
    assign dig_o    = grp[3:0];
    assign lower_nz = |bcd_reg[BW-13:0];
    assign grp_nz   = |grp;
    assign em_tens  = (dig_t != 4'd0) || (dig_o != 4'd0);
    assign em_ones  = (dig_t >= 4'd2) && (dig_o != 4'd0);
    assign em_scale = (grp_idx_reg != '0);
    assign can_emit = !out_valid_reg || m_tready;

    // Next state and the word offered to the output register
    always_comb
    begin
        state_next   = state_reg;
        sh_next      = sh_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        grp_idx_next = grp_idx_reg;
        emit_req     = 1'b0;
        emit_code    = CODE_ZERO;
        emit_last    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sh_next    = s_tdata[VALUE_WIDTH-1:0];
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end

            ST_CONV:
            begin
                bcd_next = {bcd_adj[BW-2:0], sh_reg[VALUE_WIDTH-1]};
                sh_next  = {sh_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(VALUE_WIDTH - 1))
                    state_next = ST_ZERO;
            end

            ST_ZERO:
            begin
                grp_idx_next = GW'(NGRP - 1);
                if (bcd_reg == '0)
                begin
                    emit_req  = 1'b1;
                    emit_code = CODE_ZERO;
                    emit_last = 1'b1;
                    if (can_emit)
                        state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (grp_nz)
                    state_next = ST_HUND_DIGIT;
                else if (grp_idx_reg == '0)
                    state_next = ST_IDLE;
                else
                begin
                    bcd_next     = {bcd_reg[BW-13:0], 12'd0};
                    grp_idx_next = grp_idx_reg - 1'b1;
                end
            end

            ST_HUND_DIGIT:
            begin
                if (dig_h != 4'd0)
                begin
                    emit_req  = 1'b1;
                    emit_code = word_code_t'(dig_h);
                    if (can_emit)
                        state_next = ST_HUND_WORD;
                end
                else
                begin
                    state_next = ST_TENS;
                end
            end

            ST_HUND_WORD:
            begin
                emit_req  = 1'b1;
                emit_code = CODE_HUNDRED;
                emit_last = !(em_tens || em_scale || lower_nz);
                if (can_emit)
                    state_next = ST_TENS;
            end

            ST_TENS:
            begin
                if (em_tens)
                begin
                    emit_req = 1'b1;
                    if (dig_t >= 4'd2)
                        emit_code = CODE_TENS_BASE + word_code_t'(dig_t);
                    else if (dig_t == 4'd1)
                        emit_code = CODE_TEEN_BASE + word_code_t'(dig_o);
                    else
                        emit_code = word_code_t'(dig_o);
                    emit_last = !(em_ones || em_scale || lower_nz);
                    if (can_emit)
                        state_next = ST_ONES;
                end
                else
                begin
                    state_next = ST_ONES;
                end
            end

            ST_ONES:
            begin
                if (em_ones)
                begin
                    emit_req  = 1'b1;
                    emit_code = word_code_t'(dig_o);
                    emit_last = !(em_scale || lower_nz);
                    if (can_emit)
                        state_next = ST_SCALE;
                end
                else
                begin
                    state_next = ST_SCALE;
                end
            end

            ST_SCALE:
            begin
                if (em_scale)
                begin
                    emit_req  = 1'b1;
                    emit_code = CODE_THOUSAND + word_code_t'(grp_idx_reg) - 6'd1;
                    emit_last = !lower_nz;
                    if (can_emit)
                    begin
                        bcd_next     = {bcd_reg[BW-13:0], 12'd0};
                        grp_idx_next = grp_idx_reg - 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Advance the datapath registers
    always_ff @(posedge clk)
    begin
        sh_reg      <= sh_next;
        bcd_reg     <= bcd_next;
        cnt_reg     <= cnt_next;
        grp_idx_reg <= grp_idx_next;
    end

    // Output register: load a word when free or being taken, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_req && can_emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_req && can_emit)
        begin
            out_code_reg <= emit_code;
            out_last_reg <= emit_last;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_code_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ bench/tb_number_to_word_tokens_top.sv @@
// Self-checking testbench for number_to_word_tokens_top: values in, word-code transactions checked.
`timescale 1ns / 1ps

module tb_number_to_word_tokens_top;

    import n2w_pkg::*;

    localparam int          VALUE_BITS     = 63;
    localparam int          RANDOM_VALUES  = 480;
    localparam int          MAX_SENTENCE   = 32;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          SETTLE_CYCLES  = 200;
    localparam logic [62:0] VALUE_MAX      = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        word_code_t code;
        logic       last;
    } word_tok_t;

    // Expected word sequences, one sentence per accepted value
    class word_scoreboard;
        word_tok_t   expected_words[$];
        int unsigned values_noted;
        int unsigned words_checked;
        int unsigned mismatches;
        int unsigned longest_sentence;

        function void add_word(ref word_tok_t sentence[$], input word_code_t code);
            if (sentence.size() < MAX_SENTENCE)
                sentence.insert(sentence.size(), word_tok_t'{code, 1'b0});
        endfunction

        // Spell out one three-digit group: hundreds, then tens/teens/ones
        function void add_group(ref word_tok_t sentence[$], input int unsigned grp);
            int unsigned h;
            int unsigned r;
            h = grp / 100;
            r = grp % 100;
            if (h > 0)
            begin
                add_word(sentence, word_code_t'(h));
                add_word(sentence, CODE_HUNDRED);
            end
            if (r >= 20)
            begin
                add_word(sentence, word_code_t'(CODE_TENS_BASE + r / 10));
                if (r % 10 != 0)
                    add_word(sentence, word_code_t'(r % 10));
            end
            else if (r > 0)
            begin
                add_word(sentence, word_code_t'(r));
            end
        endfunction

        // Predict the words for an accepted value and queue them
        function void note_value(logic [62:0] value);
            word_tok_t   sentence[$];
            logic [62:0] rest;
            int unsigned grp [7];
            int          ngrp;
            rest = value;
            ngrp = 0;
            values_noted++;
            if (value == '0)
            begin
                sentence.insert(sentence.size(), word_tok_t'{CODE_ZERO, 1'b1});
            end
            else
            begin
                while (rest != '0 && ngrp < 7)
                begin
                    grp[ngrp] = int'(rest % 63'd1000);
                    rest      = rest / 63'd1000;
                    ngrp++;
                end
                for (int g = ngrp - 1; g >= 0; g--)
                begin
                    if (grp[g] != 0)
                    begin
                        add_group(sentence, grp[g]);
                        if (g > 0)
                            add_word(sentence, word_code_t'(CODE_THOUSAND + g - 1));
                    end
                end
                sentence[sentence.size() - 1].last = 1'b1;
            end
            if (sentence.size() > longest_sentence)
                longest_sentence = sentence.size();
            foreach (sentence[i])
                expected_words.insert(expected_words.size(), sentence[i]);
        endfunction

        // Compare one output transaction with the oldest expected word
        function void check_word(word_code_t code, logic last);
            word_tok_t want;
            words_checked++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected word: code %0d last %0b", $realtime, code, last);
                return;
            end
            want = expected_words.pop_front();
            if (code !== want.code || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] word mismatch: expected code %0d last %0b, got code %0d last %0b",
                             $realtime, want.code, want.last, code, last);
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Anything still queued at the end never arrived
        function void flag_leftover();
            if (expected_words.size() != 0)
            begin
                $display("%0d expected words never arrived", expected_words.size());
                mismatches += expected_words.size();
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;

    word_scoreboard words_sb = new();

    number_to_word_tokens_top #(
        .VALUE_WIDTH(VALUE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every accepted output transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            words_sb.check_word(m_tdata[5:0], m_tlast);
    end

    // Receiver: change stall pattern now and then, one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = 1'($urandom_range(0, 1));
                2: m_tready = ($urandom_range(0, 3) == 0);
                default: m_tready = ((phase % 7) < 4);
            endcase
        end
    end

    // Offer one value and hold it until accepted; valid stays high afterwards
    task automatic send_value(logic [62:0] value);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, value};
        do
            @(posedge clk);
        while (!s_tready);
        words_sb.note_value(value);
    endtask

    task automatic idle_cycles(int n);
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Drop valid and wait until every expected word has come out
    task automatic drain();
        idle_cycles(0);
        while (words_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random value: from decimal groups, small values, masked bit lengths or full width
    function automatic logic [62:0] random_value();
        logic [63:0] acc;
        logic [63:0] scale;
        int          pick;
        int          nbits;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            acc   = '0;
            scale = 64'd1;
            for (int g = 0; g < 7; g++)
            begin
                if ($urandom_range(0, 2) != 0)
                    acc = acc + scale * ((g == 6) ? $urandom_range(0, 8) : $urandom_range(0, 999));
                scale = scale * 64'd1000;
            end
            return acc[62:0];
        end
        else if (pick < 60)
        begin
            return 63'($urandom_range(0, 1099));
        end
        else if (pick < 90)
        begin
            nbits = $urandom_range(1, VALUE_BITS);
            acc   = {$urandom, $urandom};
            return acc[62:0] & (VALUE_MAX >> (VALUE_BITS - nbits));
        end
        else
        begin
            acc = {$urandom, $urandom};
            return acc[62:0];
        end
    endfunction

    // Run limit
    initial
    begin
        #10ms;
        $display("number_to_word_tokens_top test failed");
        $finish;
    end

    initial
    begin
        logic [62:0] directed [$];
        int          sent;
        int          burst;
        directed = '{63'd0, 63'd1, 63'd9, 63'd10, 63'd11, 63'd15, 63'd19, 63'd20, 63'd21,
                     63'd40, 63'd99, 63'd100, 63'd101, 63'd110, 63'd119, 63'd999,
                     63'd1000, 63'd1001, 63'd1000000, 63'd1001001, 63'd1000000000000000000,
                     63'd8777777777777777777, VALUE_MAX, 63'h5555_5555_5555_5555,
                     63'h2AAA_AAAA_AAAA_AAAA};
        sent = 0;

        // Hold reset, then release it
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        // Directed values back to back
        foreach (directed[i])
            send_value(directed[i]);
        drain();

        // Random bursts; long receiver hold-off at the start, full drain half way
        hold_go = 1'b1;
        while (sent < RANDOM_VALUES)
        begin
            burst = $urandom_range(1, 10);
            for (int k = 0; k < burst && sent < RANDOM_VALUES; k++)
            begin
                send_value(random_value());
                sent++;
            end
            if (sent == RANDOM_VALUES / 2 || (sent > RANDOM_VALUES / 2 && sent - burst < RANDOM_VALUES / 2))
                drain();
            else if ($urandom_range(0, 9) < 3)
                ;
            else
                idle_cycles($urandom_range(1, 12));
        end
        drain();

        words_sb.flag_leftover();
        $display("Sent %0d values (%0d directed), checked %0d words, longest sentence %0d words.",
                 words_sb.values_noted, directed.size(), words_sb.words_checked,
                 words_sb.longest_sentence);
        $display("Mismatches: %0d", words_sb.mismatches);
        if (words_sb.mismatches == 0)
            $display("number_to_word_tokens_top test passed");
        else
            $display("number_to_word_tokens_top test failed");
        $finish;
    end

endmodule
